// ----- sv/brb_pkg.sv -----
package brb_pkg;

  // Fixed field widths
  localparam int DATA_W   = 8;
  localparam int REQ_W    = 7;
  localparam int CNT_W    = 10;
  localparam int CFG_W    = 4;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;

  // Packed stream widths, rounded up to whole bytes
  localparam int S_TDATA_W = ((DATA_W + REQ_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((DATA_W + 2 * CNT_W + 7) / 8) * 8;

  // Defaults and reset values
  localparam int DEF_MAX_SIZE_BITS = 10;
  localparam int DEF_MAX_RUN       = 64;
  localparam int SIZE_BITS_RESET   = 10;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

endpackage

// ----- sv/byte_ring_buffer_core.sv -----
// Byte ring buffer with a power-of-two size chosen at run time.
//
// Slave channel: one beat per operation. tuser carries the operation
// (put, read run, peek run, clear); tdata carries the byte to put and the
// requested run length. Master channel: one beat per returned byte, or a
// single beat for put, clear and empty runs; tlast marks the final beat of
// an operation, tuser carries the status, tdata the byte and the readable
// and writable counts after that beat.
// Put and clear may arrive back to back; a result appears in the output
// register in the cycle after acceptance.
// A read or peek of n bytes first fetches the first byte from the byte
// store, then gives one byte per cycle while the master side accepts, paced
// by the single read port of the store. The next operation is taken once the
// final beat has been loaded into the output register.
// cfg_we_i/cfg_wdata_i write log2 of the size in use (clamped to the valid
// range) and clear both pointers; write it only while the block is idle.
// Reset empties the buffer and selects log2 size SIZE_BITS_RESET (at most
// MaxSizeBits); the byte store is not cleared. If the master side stalls,
// the output register holds its beat; no further beat or operation is taken.
module byte_ring_buffer_core #(
  parameter int MaxSizeBits = brb_pkg::DEF_MAX_SIZE_BITS,
  parameter int MaxRun      = brb_pkg::DEF_MAX_RUN
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // size register
  input  logic                             cfg_we_i,
  input  logic [brb_pkg::CFG_W-1:0]        cfg_wdata_i,
  // operation beats
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] data_in, [14:8] request_count, [15] zero
  input  logic [brb_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] operation
  input  logic [brb_pkg::OP_W-1:0]         s_axis_tuser,
  // result beats
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] data_out, [17:8] readable_count, [27:18] writable_count, [31:28] zero
  output logic [brb_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // [1:0] status
  output logic [brb_pkg::STAT_W-1:0]       m_axis_tuser,
  output logic                             m_axis_tlast
);

  import brb_pkg::*;

  localparam int PtrW     = MaxSizeBits;
  localparam int Depth    = 1 << MaxSizeBits;
  localparam int EffW     = $clog2(MaxSizeBits + 1);
  localparam int CmpW     = (PtrW > REQ_W) ? PtrW : REQ_W;
  localparam int ResetEff = (SIZE_BITS_RESET > MaxSizeBits) ? MaxSizeBits : SIZE_BITS_RESET;

  // Input unpacking
  op_e               op;
  logic [DATA_W-1:0] data_in;
  logic [REQ_W-1:0]  req_cnt;

  assign op      = op_e'(s_axis_tuser);
  assign data_in = s_axis_tdata[DATA_W-1:0];
  assign req_cnt = s_axis_tdata[DATA_W +: REQ_W];

  // Control state
  state_e            state_q, state_d;
  logic [PtrW-1:0]   rptr_q, rptr_d;
  logic [PtrW-1:0]   wptr_q, wptr_d;
  logic [PtrW-1:0]   pos_q, pos_d;
  logic [PtrW-1:0]   mask_q, mask_d;
  logic [REQ_W-1:0]  cnt_q, cnt_d;
  logic              adv_q, adv_d;

  // Byte store
  logic [DATA_W-1:0] mem [Depth];
  logic [DATA_W-1:0] rd_data_q;
  logic              mem_we;

  // Output register
  logic              ovalid_q;
  logic [DATA_W-1:0] odata_q, odata_d;
  status_e           ostat_q, ostat_d;
  logic              olast_q, olast_d;
  logic [CNT_W-1:0]  ordc_q, owrc_q;
  logic              load;

  // Working values
  logic              out_free;
  logic              accept;
  logic [PtrW-1:0]   readable_now;
  logic [PtrW-1:0]   writable_now;
  logic [PtrW-1:0]   readable_nxt;
  logic [PtrW-1:0]   pos_inc;
  logic [REQ_W-1:0]  req_clip;
  logic [REQ_W-1:0]  run_len;
  logic [EffW-1:0]   cfg_eff;

  assign out_free      = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign readable_now = (wptr_q - rptr_q) & mask_q;
  assign writable_now = mask_q - readable_now;
  assign pos_inc      = (pos_q + PtrW'(1)) & mask_q;

  // Run length: request clipped to the longest run and to what is stored
  always_comb begin
    if (int'(req_cnt) > MaxRun) begin
      req_clip = REQ_W'(MaxRun);
    end else begin
      req_clip = req_cnt;
    end
    if (CmpW'(req_clip) > CmpW'(readable_now)) begin
      run_len = REQ_W'(readable_now);
    end else begin
      run_len = req_clip;
    end
  end

  // Size register decode, clamped to the supported range
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_eff = EffW'(1);
    end else if (int'(cfg_wdata_i) > MaxSizeBits) begin
      cfg_eff = EffW'(MaxSizeBits);
    end else begin
      cfg_eff = EffW'(cfg_wdata_i);
    end
  end

  // Next state and result selection
  always_comb begin
    state_d = state_q;
    rptr_d  = rptr_q;
    wptr_d  = wptr_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    adv_d   = adv_q;
    mask_d  = mask_q;
    mem_we  = 1'b0;
    load    = 1'b0;
    odata_d = '0;
    ostat_d = STAT_OK;
    olast_d = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        pos_d = rptr_q;
        if (accept) begin
          load = 1'b1;
          unique case (op)
            OP_PUT: begin
              if (writable_now == '0) begin
                ostat_d = STAT_FULL;
              end else begin
                mem_we = 1'b1;
                wptr_d = (wptr_q + PtrW'(1)) & mask_q;
              end
            end
            OP_CLEAR: begin
              rptr_d = '0;
              wptr_d = '0;
            end
            OP_READ, OP_PEEK: begin
              if (run_len == '0) begin
                ostat_d = STAT_EMPTY;
              end else begin
                // first byte comes from the store next cycle
                load    = 1'b0;
                state_d = ST_RUN;
                cnt_d   = run_len;
                adv_d   = (op == OP_READ);
              end
            end
          endcase
        end
      end
      ST_RUN: begin
        if (out_free) begin
          load    = 1'b1;
          odata_d = rd_data_q;
          olast_d = (cnt_q == REQ_W'(1));
          pos_d   = pos_inc;
          cnt_d   = cnt_q - REQ_W'(1);
          if (adv_q) begin
            rptr_d = pos_inc;
          end
          if (olast_d) begin
            state_d = ST_IDLE;
          end
        end
      end
    endcase

    // size write clears the pointers
    if (cfg_we_i) begin
      rptr_d = '0;
      wptr_d = '0;
      mask_d = ~({PtrW{1'b1}} << cfg_eff);
    end
  end

  assign readable_nxt = (wptr_d - rptr_d) & mask_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rptr_q   <= '0;
      wptr_q   <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
      adv_q    <= 1'b0;
      mask_q   <= ~({PtrW{1'b1}} << ResetEff);
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rptr_q  <= rptr_d;
      wptr_q  <= wptr_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      adv_q   <= adv_d;
      mask_q  <= mask_d;
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Byte store: one write port, one registered read port at the run position
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wptr_q] <= data_in;
    end
    rd_data_q <= mem[pos_d];
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      odata_q <= odata_d;
      ostat_q <= ostat_d;
      olast_q <= olast_d;
      ordc_q  <= CNT_W'(readable_nxt);
      owrc_q  <= CNT_W'(mask_q - readable_nxt);
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - DATA_W - 2 * CNT_W){1'b0}}, owrc_q, ordc_q, odata_q};
  assign m_axis_tuser  = ostat_q;
  assign m_axis_tlast  = olast_q;

endmodule
